>>> design/tcbc_pkg.sv
// ----------------------------------------------------------------------------
// tcbc_pkg
// Shared types, constants and helpers of the traffic class busy counter.
// ----------------------------------------------------------------------------
package tcbc_pkg;

	localparam int MAX_USERS_DEFAULT = 32;

	localparam int PAIRS    = 16;
	localparam int PAIR_W   = 4;
	localparam int CNT_W    = 16;
	localparam int BUSY_W   = 6;
	localparam int LEN_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [BUSY_W-1:0] BUSY_MAX  = '1;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [LEN_W-1:0] MIN_LEN_RESET = 16'd256;
	localparam logic [LEN_W-1:0] BUSY_THR_RESET = 16'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PACKET_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUSY_THRESHOLD    = 1'd1;

	// Request function codes.
	localparam logic [1:0] FUNC_PACKET = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// Access category codes.
	localparam logic [1:0] AC_BE = 2'd0;
	localparam logic [1:0] AC_BK = 2'd1;
	localparam logic [1:0] AC_VI = 2'd2;
	localparam logic [1:0] AC_VO = 2'd3;

	// One memory row holds all sixteen counters of a user slot.
	typedef logic [PAIRS-1:0][CNT_W-1:0]  row_t;
	typedef logic [PAIRS-1:0][BUSY_W-1:0] busy_vec_t;

	typedef struct packed {
		logic              slot_ok;
		logic              count;
		logic [PAIR_W-1:0] pair;
	} pkt_info_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_row;
		logic clr_all;
	} mem_ctl_t;

	typedef struct packed {
		logic clear;
		logic acc_en;
	} acc_ctl_t;

	// 802.11 user priority to access category mapping.
	function automatic logic [1:0] tid_to_ac(input logic [2:0] tid);
		logic [1:0] ac;
		unique case (tid)
			3'd0, 3'd3: ac = AC_BE;
			3'd1, 3'd2: ac = AC_BK;
			3'd4, 3'd5: ac = AC_VI;
			default:    ac = AC_VO;
		endcase
		return ac;
	endfunction

endpackage

>>> design/tcbc_classify.sv
// ----------------------------------------------------------------------------
// tcbc_classify
// Decides whether a packet request is counted and which counter it hits.
// ----------------------------------------------------------------------------
module tcbc_classify #(
	parameter int MAX_USERS = tcbc_pkg::MAX_USERS_DEFAULT
) (
	input  logic [4:0]                   user_index,
	input  logic                         direction,
	input  logic [2:0]                   tid,
	input  logic [7:0]                   ip_protocol,
	input  logic [tcbc_pkg::LEN_W-1:0]   ip_total_length,
	input  logic [3:0]                   ip_header_words,
	input  logic [3:0]                   tcp_data_offset,
	input  logic [tcbc_pkg::LEN_W-1:0]   min_len,
	output tcbc_pkg::pkt_info_t          info
);

	logic [6:0] hdr_bytes;
	logic       long_enough;
	logic       has_payload;
	logic       is_udp;
	logic       is_tcp;

	// IP header plus TCP header length; a pure ACK has exactly this length.
	assign hdr_bytes   = {1'b0, ip_header_words, 2'b00} + {1'b0, tcp_data_offset, 2'b00};
	assign has_payload = ip_total_length != {9'd0, hdr_bytes};
	assign long_enough = ip_total_length >= min_len;
	assign is_udp      = ip_protocol == tcbc_pkg::PROTO_UDP;
	assign is_tcp      = ip_protocol == tcbc_pkg::PROTO_TCP;

	always_comb begin
		info.slot_ok = 32'(user_index) < MAX_USERS;
		info.count   = info.slot_ok && long_enough && (is_udp || (is_tcp && has_payload));
		info.pair    = {tcbc_pkg::tid_to_ac(tid), is_udp, direction};
	end

endmodule

>>> design/tcbc_count_mem.sv
// ----------------------------------------------------------------------------
// tcbc_count_mem
// Counter memory, one row of sixteen counters per user slot, with row valid bits.
// ----------------------------------------------------------------------------
module tcbc_count_mem #(
	parameter int DEPTH  = tcbc_pkg::MAX_USERS_DEFAULT,
	parameter int ADDR_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcbc_pkg::mem_ctl_t   ctl,
	input  logic [ADDR_W-1:0]    rd_addr,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  tcbc_pkg::row_t       wr_row,
	input  logic [ADDR_W-1:0]    clr_addr,
	output tcbc_pkg::row_t       rd_row,
	output logic                 rd_valid
);

	tcbc_pkg::row_t mem_q [DEPTH];
	tcbc_pkg::row_t rd_row_q;
	logic           rd_valid_q;
	logic [DEPTH-1:0] row_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (ctl.rd_en) begin
			rd_row_q <= mem_q[rd_addr];
		end
	end

	// A row that is not valid reads back with rd_valid low; its readers treat it as all-zero counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
			if (ctl.clr_all) begin
				row_valid_q <= '0;
			end else begin
				if (ctl.wr_en) begin
					row_valid_q[wr_addr] <= 1'b1;
				end
				if (ctl.clr_row) begin
					row_valid_q[clr_addr] <= 1'b0;
				end
			end
		end
	end

	assign rd_row   = rd_row_q;
	assign rd_valid = rd_valid_q;

endmodule

>>> design/tcbc_busy_acc.sv
// ----------------------------------------------------------------------------
// tcbc_busy_acc
// Sixteen saturating busy-user accumulators fed one memory row per cycle while enabled.
// ----------------------------------------------------------------------------
module tcbc_busy_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcbc_pkg::acc_ctl_t           ctl,
	input  tcbc_pkg::row_t               row,
	input  logic                         row_valid,
	input  logic [tcbc_pkg::CNT_W-1:0]   threshold,
	output tcbc_pkg::busy_vec_t          busy
);

	tcbc_pkg::busy_vec_t busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (ctl.clear) begin
			busy_q <= '0;
		end else if (ctl.acc_en && row_valid) begin
			for (int p = 0; p < tcbc_pkg::PAIRS; p++) begin
				if (row[p] > threshold && busy_q[p] != tcbc_pkg::BUSY_MAX) begin
					busy_q[p] <= busy_q[p] + 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;

endmodule

>>> design/traffic_class_busy_counter.sv
// ----------------------------------------------------------------------------
// traffic_class_busy_counter
// Per-user packet counters by access category and traffic type, busy scan.
// Counted packet: read of its slot row, then write back; dropped packet or clear: handled on acceptance.
// Tick: a scan of every slot row and a drain step, then 16 results, at most 1 per cycle.
// Reset clears the row valid bits at once, so every counter reads zero; no sweep.
// ----------------------------------------------------------------------------
module traffic_class_busy_counter #(
	parameter int MAX_USERS = tcbc_pkg::MAX_USERS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_write,
	input  logic [tcbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcbc_pkg::CFG_W-1:0]       cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [4:0]                       user_index,
	input  logic                             direction,
	input  logic [2:0]                       tid,
	input  logic [7:0]                       ip_protocol,
	input  logic [15:0]                      ip_total_length,
	input  logic [3:0]                       ip_header_words,
	input  logic [3:0]                       tcp_data_offset,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       access_category,
	output logic [1:0]                       traffic_type,
	output logic [5:0]                       busy_user_count,
	output logic                             last
);

	// Width of a user slot address into the counter memory.
	localparam int ADDR_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_USERS - 1);

	// The controller handles one request at a time. A counted packet reads its
	// slot row, then writes the row back with one counter bumped. Since the
	// write always lands before the next request is taken, no read can see a
	// stale row and no forwarding path is needed.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [tcbc_pkg::LEN_W-1:0] min_len_q;
	logic [tcbc_pkg::CNT_W-1:0] busy_thr_q;

	logic                    accept;
	tcbc_pkg::pkt_info_t     info;
	logic [7:0]              slot_ext;
	logic [ADDR_W-1:0]       slot_addr;

	logic [ADDR_W-1:0]       slot_s1;
	logic [tcbc_pkg::PAIR_W-1:0] pair_s1;
	logic                    scan_pend_s1;

	logic [ADDR_W-1:0]       scan_q;
	logic [tcbc_pkg::PAIR_W-1:0] emit_q;

	tcbc_pkg::mem_ctl_t      mem_ctl;
	tcbc_pkg::acc_ctl_t      acc_ctl;
	logic [ADDR_W-1:0]       rd_addr;
	tcbc_pkg::row_t          rd_row;
	logic                    rd_valid;
	tcbc_pkg::row_t          cur_row;
	tcbc_pkg::row_t          new_row;
	tcbc_pkg::busy_vec_t     busy;

	logic                    emit_load;
	logic                    out_valid_q;
	logic [1:0]              ac_q;
	logic [1:0]              type_q;
	logic [5:0]              busy_cnt_q;
	logic                    last_q;

	// ------------------------------------------------------------------------
	// Configuration registers. Write only while the block is idle; the block does not enforce it.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q  <= tcbc_pkg::MIN_LEN_RESET;
			busy_thr_q <= tcbc_pkg::BUSY_THR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcbc_pkg::REG_MIN_PACKET_LENGTH: min_len_q  <= cfg_data;
				tcbc_pkg::REG_BUSY_THRESHOLD:    busy_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Request decode. The slot index is resized to the memory address width;
	// out-of-range slots are filtered by slot_ok before any memory access.
	// ------------------------------------------------------------------------
	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;

	assign slot_ext  = {3'd0, user_index};
	assign slot_addr = slot_ext[ADDR_W-1:0];

	tcbc_classify #(
		.MAX_USERS (MAX_USERS)
	) u_classify (
		.user_index      (user_index),
		.direction       (direction),
		.tid             (tid),
		.ip_protocol     (ip_protocol),
		.ip_total_length (ip_total_length),
		.ip_header_words (ip_header_words),
		.tcp_data_offset (tcp_data_offset),
		.min_len         (min_len_q),
		.info            (info)
	);

	// ------------------------------------------------------------------------
	// Sequencer. A tick walks every slot row, one read per cycle, then a drain
	// state lets the last row reach the accumulators; the drain state also
	// drops every row valid bit, which zeroes all counters for the new period.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == tcbc_pkg::FUNC_PACKET && info.count) begin
						state_d = ST_UPDATE;
					end else if (func == tcbc_pkg::FUNC_TICK) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_UPDATE: state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_q == LAST_SLOT) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_load && emit_q == tcbc_pkg::PAIR_W'(tcbc_pkg::PAIRS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			emit_q       <= '0;
			scan_pend_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			scan_pend_s1 <= state_q == ST_SCAN;
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (state_q == ST_DRAIN) begin
				emit_q <= '0;
			end else if (emit_load) begin
				emit_q <= emit_q + 1'b1;
			end
		end
	end

	// The packet's target is held for the write-back cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1 <= slot_addr;
			pair_s1 <= info.pair;
		end
	end

	// ------------------------------------------------------------------------
	// Counter memory and read-modify-write of one counter lane.
	// ------------------------------------------------------------------------
	always_comb begin
		mem_ctl.rd_en   = (accept && func == tcbc_pkg::FUNC_PACKET && info.count)
		                  || state_q == ST_SCAN;
		mem_ctl.wr_en   = state_q == ST_UPDATE;
		mem_ctl.clr_row = accept && func == tcbc_pkg::FUNC_CLEAR && info.slot_ok;
		mem_ctl.clr_all = state_q == ST_DRAIN;
	end

	assign rd_addr = (state_q == ST_SCAN) ? scan_q : slot_addr;

	tcbc_count_mem #(
		.DEPTH  (MAX_USERS),
		.ADDR_W (ADDR_W)
	) u_count_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (slot_s1),
		.wr_row   (new_row),
		.clr_addr (slot_addr),
		.rd_row   (rd_row),
		.rd_valid (rd_valid)
	);

	// A row never written since reset, a tick or a clear reads as zeros.
	always_comb begin
		cur_row = rd_valid ? rd_row : '0;
		new_row = cur_row;
		if (cur_row[pair_s1] != tcbc_pkg::COUNT_MAX) begin
			new_row[pair_s1] = cur_row[pair_s1] + 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Busy accumulation over the scanned rows.
	// ------------------------------------------------------------------------
	always_comb begin
		acc_ctl.clear  = accept && func == tcbc_pkg::FUNC_TICK;
		acc_ctl.acc_en = scan_pend_s1;
	end

	tcbc_busy_acc u_busy_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (acc_ctl),
		.row       (rd_row),
		.row_valid (rd_valid),
		.threshold (busy_thr_q),
		.busy      (busy)
	);

	// ------------------------------------------------------------------------
	// Result register. Results go out in pair order, access category outer
	// and traffic type inner; a new result loads whenever the register is
	// empty or its current result is being taken.
	// ------------------------------------------------------------------------
	assign emit_load = state_q == ST_EMIT && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			ac_q       <= emit_q[3:2];
			type_q     <= emit_q[1:0];
			busy_cnt_q <= busy[emit_q];
			last_q     <= emit_q == tcbc_pkg::PAIR_W'(tcbc_pkg::PAIRS - 1);
		end
	end

	assign out_valid       = out_valid_q;
	assign access_category = ac_q;
	assign traffic_type    = type_q;
	assign busy_user_count = busy_cnt_q;
	assign last            = last_q;

`ifndef SYNTHESIS
	// The counter memory is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.rd_en && mem_ctl.wr_en))
		else $error("counter memory read and write overlap");

	// A write-back always follows directly on an accepted packet.
	a_update_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> $past(accept && func == tcbc_pkg::FUNC_PACKET))
		else $error("write-back without a packet request");

	// A new result only appears while results of a tick are being emitted.
	a_result_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit phase");

	// The scan address stays inside the memory.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q <= LAST_SLOT)
		else $error("scan address beyond last slot");

	// The last row read of a scan is accumulated in the drain cycle.
	a_drain_accumulates: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> acc_ctl.acc_en && $past(state_q == ST_SCAN))
		else $error("drain cycle without pending scan data");
`endif

endmodule

>>> tb/sv/tb_traffic_class_busy_counter.sv
// ----------------------------------------------------------------------------
// tb_traffic_class_busy_counter
// Self-checking bench for the per-user traffic class busy counter. A short
// table of hand-picked requests, then randomized phases under several register
// settings. Every tick report is checked against a behavioral model or a typed all-zero report.
// ----------------------------------------------------------------------------
module tb_traffic_class_busy_counter;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int USERS         = tcbc_pkg::MAX_USERS_DEFAULT;
	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 7;
	// A counted packet only needs its read and write back, so this is ample before a register write.
	localparam int SETTLE_CYCLES = 8;
	// A tick needs a full row scan plus sixteen reports, so give it room at the end.
	localparam int DRAIN_CYCLES  = 64;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 50;

	// The block has no name for the fourth function code; it must be ignored.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic DIR_RX = 1'b0;
	localparam logic DIR_TX = 1'b1;

	localparam logic [1:0] TT_RX_TCP = 2'd0;
	localparam logic [1:0] TT_TX_TCP = 2'd1;
	localparam logic [1:0] TT_RX_UDP = 2'd2;
	localparam logic [1:0] TT_TX_UDP = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [4:0]  user;
		logic        dir;
		logic [2:0]  tid;
		logic [7:0]  proto;
		logic [15:0] len;
		logic [3:0]  ihl;
		logic [3:0]  doff;
	} request_t;

	typedef struct packed {
		logic [1:0] ac;
		logic [1:0] tt;
		logic [5:0] busy;
		logic       last;
	} busy_report_t;

	typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

	// One line of the directed table. A config line writes both registers. A
	// request line may repeat its request, and a tick may carry a typed report
	// of all zeros instead of the modeled one.
	typedef struct {
		row_kind_t   kind;
		request_t    req;
		int unsigned reps;
		bit          zero_report;
		logic [15:0] min_len;
		logic [15:0] thr;
	} plan_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                           cfg_write = 1'b0;
	logic [tcbc_pkg::CFG_IDX_W-1:0] cfg_index = tcbc_pkg::REG_MIN_PACKET_LENGTH;
	logic [tcbc_pkg::CFG_W-1:0]     cfg_data  = '0;

	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [1:0]  func            = tcbc_pkg::FUNC_PACKET;
	logic [4:0]  user_index      = '0;
	logic        direction       = DIR_RX;
	logic [2:0]  tid             = '0;
	logic [7:0]  ip_protocol     = '0;
	logic [15:0] ip_total_length = '0;
	logic [3:0]  ip_header_words = '0;
	logic [3:0]  tcp_data_offset = '0;

	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] access_category;
	logic [1:0] traffic_type;
	logic [5:0] busy_user_count;
	logic       last;

	// Model state: one packet tally per slot and pair, and copies of the registers.
	logic [tcbc_pkg::CNT_W-1:0] pkt_tally [USERS][tcbc_pkg::PAIRS];
	logic [15:0]      min_len_cfg  = tcbc_pkg::MIN_LEN_RESET;
	logic [15:0]      busy_thr_cfg = tcbc_pkg::BUSY_THR_RESET;

	busy_report_t pending_reports[$];
	plan_row_t    directed_plan[$];
	int unsigned  failures   = 0;
	int unsigned  stall_left = 0;
	// When set, neither side inserts idle cycles.
	bit           calm       = 1'b0;

	traffic_class_busy_counter #(
		.MAX_USERS(USERS)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.user_index     (user_index),
		.direction      (direction),
		.tid            (tid),
		.ip_protocol    (ip_protocol),
		.ip_total_length(ip_total_length),
		.ip_header_words(ip_header_words),
		.tcp_data_offset(tcp_data_offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.access_category(access_category),
		.traffic_type   (traffic_type),
		.busy_user_count(busy_user_count),
		.last           (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		foreach (pkt_tally[u, p]) pkt_tally[u][p] = '0;
	end

	// Applies one accepted request to the model. A counted packet bumps one tally, a
	// tick reports all sixteen pairs and wipes every tally, a clear wipes one
	// slot. When report is low the tick still wipes, but its reports are not
	// queued, since the caller supplies typed ones.
	task automatic account_request(input request_t r, input bit report);
		int           payload;
		logic [1:0]   ac;
		logic [1:0]   tt;
		logic [3:0]   pair;
		bit           hit;
		int unsigned  busy;
		busy_report_t rep;
		case (r.func)
			tcbc_pkg::FUNC_PACKET: begin
				if (r.user < USERS && r.len >= min_len_cfg) begin
					// Standard user priority to access category mapping.
					case (r.tid)
						3'd0, 3'd3: ac = tcbc_pkg::AC_BE;
						3'd1, 3'd2: ac = tcbc_pkg::AC_BK;
						3'd4, 3'd5: ac = tcbc_pkg::AC_VI;
						default:    ac = tcbc_pkg::AC_VO;
					endcase
					hit = 1'b0;
					tt  = TT_RX_TCP;
					if (r.proto == tcbc_pkg::PROTO_UDP) begin
						hit = 1'b1;
						tt  = (r.dir == DIR_TX) ? TT_TX_UDP : TT_RX_UDP;
					end else if (r.proto == tcbc_pkg::PROTO_TCP) begin
						// The payload length is signed; a header longer than the
						// whole packet yields a negative value, which still counts.
						payload = int'(r.len) - int'(r.ihl) * 4;
						if (payload != int'(r.doff) * 4) begin
							hit = 1'b1;
							tt  = (r.dir == DIR_TX) ? TT_TX_TCP : TT_RX_TCP;
						end
					end
					pair = {ac, tt};
					if (hit && pkt_tally[r.user][pair] != tcbc_pkg::COUNT_MAX)
						pkt_tally[r.user][pair] = pkt_tally[r.user][pair] + 1'b1;
				end
			end
			tcbc_pkg::FUNC_TICK: begin
				for (int p = 0; p < tcbc_pkg::PAIRS; p++) begin
					pair = p[3:0];
					busy = 0;
					for (int u = 0; u < USERS; u++) begin
						if (pkt_tally[u][pair] > busy_thr_cfg && busy < tcbc_pkg::BUSY_MAX)
							busy++;
					end
					rep.ac   = pair[3:2];
					rep.tt   = pair[1:0];
					rep.busy = busy[5:0];
					rep.last = (p == tcbc_pkg::PAIRS - 1);
					if (report)
						pending_reports.push_back(rep);
				end
				foreach (pkt_tally[u, p]) pkt_tally[u][p] = '0;
			end
			tcbc_pkg::FUNC_CLEAR: begin
				if (r.user < USERS)
					for (int p = 0; p < tcbc_pkg::PAIRS; p++) pkt_tally[r.user][p] = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Offers one request, possibly after a burst of idle cycles, and returns at
	// the edge that accepts it. It must be called right after a rising edge. The
	// valid stays high on return so that back-to-back requests need no drop.
	task automatic send_request(input request_t r, input bit report);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= r.func;
		user_index      <= r.user;
		direction       <= r.dir;
		tid             <= r.tid;
		ip_protocol     <= r.proto;
		ip_total_length <= r.len;
		ip_header_words <= r.ihl;
		tcp_data_offset <= r.doff;
		do @(posedge clk); while (!in_ready);
		account_request(r, report);
	endtask

	// Stops offering requests and waits until every queued report has arrived,
	// then lets the block finish any packet still in flight.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers, one per cycle, while the block is idle.
	task automatic program_registers(input logic [15:0] min_len, input logic [15:0] thr);
		drain_block();
		cfg_write <= 1'b1;
		cfg_index <= tcbc_pkg::REG_MIN_PACKET_LENGTH;
		cfg_data  <= min_len;
		@(posedge clk);
		cfg_index <= tcbc_pkg::REG_BUSY_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_write    <= 1'b0;
		min_len_cfg  = min_len;
		busy_thr_cfg = thr;
	endtask

	function automatic plan_row_t req_row(input logic [1:0] f, input logic [4:0] u,
		input logic d, input logic [2:0] t, input logic [7:0] pr,
		input logic [15:0] len, input logic [3:0] ihl, input logic [3:0] doff,
		input int unsigned reps = 1);
		plan_row_t row;
		row.kind        = ROW_REQUEST;
		row.req         = '{func: f, user: u, dir: d, tid: t, proto: pr, len: len,
			ihl: ihl, doff: doff};
		row.reps        = reps;
		row.zero_report = 1'b0;
		row.min_len     = '0;
		row.thr         = '0;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [15:0] min_len, input logic [15:0] thr);
		plan_row_t row;
		row         = req_row(tcbc_pkg::FUNC_PACKET, 5'd0, DIR_RX, 3'd0, 8'd0, 16'd0,
			4'd0, 4'd0, 0);
		row.kind    = ROW_CONFIG;
		row.min_len = min_len;
		row.thr     = thr;
		return row;
	endfunction

	function automatic plan_row_t tick_row(input bit zero_report);
		plan_row_t row;
		row             = req_row(tcbc_pkg::FUNC_TICK, 5'd0, DIR_RX, 3'd0, 8'd0, 16'd0,
			4'd0, 4'd0);
		row.zero_report = zero_report;
		return row;
	endfunction

	// A random request. Most are well-formed TCP or UDP packets aimed at a
	// handful of slots so that tallies climb past the threshold; the rest are
	// ticks, clears, the unused code, odd protocols and pure ACKs.
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			r.func = tcbc_pkg::FUNC_TICK;
		else if (pick < 10)
			r.func = tcbc_pkg::FUNC_CLEAR;
		else if (pick < 12)
			r.func = FUNC_UNUSED;
		else
			r.func = tcbc_pkg::FUNC_PACKET;
		r.user = 5'($urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 31));
		r.dir  = 1'($urandom_range(0, 1));
		r.tid  = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.proto = tcbc_pkg::PROTO_TCP;
		else if (pick < 85)
			r.proto = tcbc_pkg::PROTO_UDP;
		else
			r.proto = 8'($urandom_range(0, 255));
		r.ihl  = 4'($urandom_range(0, 15));
		r.doff = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.len = 16'hFFFF;
		else if (pick < 10)
			r.len = 16'h0000;
		else if (pick < 45)
			r.len = 16'($urandom_range(0, 65535));
		else
			r.len = 16'($urandom_range(0, 600));
		// Make a share of the TCP packets header-only so that they are skipped.
		if (r.proto == tcbc_pkg::PROTO_TCP && $urandom_range(0, 4) == 0)
			r.len = 16'(r.ihl) * 16'd4 + 16'(r.doff) * 16'd4;
		return r;
	endfunction

	// Each report handed over is compared field by field with the oldest one
	// the model has queued.
	function automatic void compare_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		busy_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				failures++;
				$display("%0t: unexpected report, expected none, actual ac %0d type %0d busy %0d",
					$time, access_category, traffic_type, busy_user_count);
			end else begin
				want = pending_reports.pop_front();
				compare_field("access_category", 32'(want.ac), 32'(access_category));
				compare_field("traffic_type", 32'(want.tt), 32'(traffic_type));
				compare_field("busy_user_count", 32'(want.busy), 32'(busy_user_count));
				compare_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// The receiver stalls in random bursts, unless calm.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		logic [15:0] min_len;
		logic [15:0] thr;
		plan_row_t   row;

		// Directed table. Lower the registers so that every packet length counts
		// and any single packet makes its user busy.
		directed_plan.push_back(cfg_row(16'h0000, 16'h0000));
		// Nothing has been counted since reset, so every pair reports zero.
		directed_plan.push_back(tick_row(1'b1));
		// Shortest and longest packets, first and last slot, UDP both ways.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd0, DIR_RX, 3'd0,
			tcbc_pkg::PROTO_UDP, 16'h0000, 4'd0, 4'd0));
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd31, DIR_TX, 3'd7,
			tcbc_pkg::PROTO_UDP, 16'hFFFF, 4'd15, 4'd15));
		// A pure ACK: 40 bytes with a 20-byte IP and a 20-byte TCP header.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd1, DIR_RX, 3'd1,
			tcbc_pkg::PROTO_TCP, 16'd40, 4'd5, 4'd5));
		// One payload byte, so it counts.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd2, DIR_TX, 3'd2,
			tcbc_pkg::PROTO_TCP, 16'd41, 4'd5, 4'd5));
		// The IP header alone is longer than the packet; the negative payload counts.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd3, DIR_RX, 3'd3,
			tcbc_pkg::PROTO_TCP, 16'd0, 4'd15, 4'd0));
		// Both headers at their largest and no payload.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd4, DIR_TX, 3'd4,
			tcbc_pkg::PROTO_TCP, 16'd120, 4'd15, 4'd15));
		// Neither TCP nor UDP.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd5, DIR_RX, 3'd5,
			8'd0, 16'd300, 4'd5, 4'd5));
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd6, DIR_TX, 3'd6,
			8'hFF, 16'd300, 4'd5, 4'd5));
		// The unused function code must change nothing.
		directed_plan.push_back(req_row(FUNC_UNUSED, 5'd7, DIR_TX, 3'd7,
			tcbc_pkg::PROTO_UDP, 16'd300, 4'd5, 4'd5));
		// Clearing the last slot drops the long UDP packet counted above.
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_CLEAR, 5'd31, DIR_RX, 3'd0,
			8'd0, 16'd0, 4'd0, 4'd0));
		directed_plan.push_back(tick_row(1'b0));
		// The previous tick wiped everything.
		directed_plan.push_back(tick_row(1'b1));
		// Registers at their top: only a full-length packet counts and nobody is busy.
		directed_plan.push_back(cfg_row(16'hFFFF, 16'hFFFF));
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd8, DIR_RX, 3'd0,
			tcbc_pkg::PROTO_UDP, 16'hFFFE, 4'd5, 4'd5));
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd8, DIR_TX, 3'd0,
			tcbc_pkg::PROTO_UDP, 16'hFFFF, 4'd5, 4'd5));
		directed_plan.push_back(tick_row(1'b0));
		// Threshold edge: three packets lift one user above a threshold of two,
		// two packets leave another one exactly at it.
		directed_plan.push_back(cfg_row(16'h0000, 16'h0002));
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd9, DIR_TX, 3'd6,
			tcbc_pkg::PROTO_UDP, 16'd100, 4'd5, 4'd5, 3));
		directed_plan.push_back(req_row(tcbc_pkg::FUNC_PACKET, 5'd10, DIR_RX, 3'd4,
			tcbc_pkg::PROTO_TCP, 16'd100, 4'd5, 4'd5, 2));
		directed_plan.push_back(tick_row(1'b0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.kind == ROW_CONFIG) begin
				program_registers(row.min_len, row.thr);
			end else begin
				// Repeated requests go back to back.
				calm = (row.reps > 1);
				repeat (row.reps) send_request(row.req, !row.zero_report);
				calm = 1'b0;
				if (row.zero_report) begin
					for (int p = 0; p < tcbc_pkg::PAIRS; p++) begin
						pending_reports.push_back('{ac: p[3:2], tt: p[1:0], busy: 6'd0,
							last: (p == tcbc_pkg::PAIRS - 1)});
					end
				end
			end
		end

		// Random phases, each under its own register setting. The first two use
		// the extremes; the last runs with no idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				min_len = 16'h0000;
				thr     = 16'h0000;
			end else if (ph == 1) begin
				min_len = 16'hFFFF;
				thr     = 16'hFFFF;
			end else begin
				min_len = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 400));
				thr     = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 4));
			end
			program_registers(min_len, thr);
			calm = (ph == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request(), 1'b1);
			// Close every phase with a tick so its tallies are reported.
			row = tick_row(1'b0);
			send_request(row.req, 1'b1);
		end

		drain_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS traffic_class_busy_counter");
		else
			$display("FAIL traffic_class_busy_counter");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout, %0d reports still expected", $time, pending_reports.size());
		$display("FAIL traffic_class_busy_counter");
		$finish;
	end

endmodule
